@@ rtl/psn_pkg.sv @@
// psn_pkg: shared types and constants for the point set normalizer
// no dependencies; imported by every module of the block
package psn_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int PT_CW      = $clog2(MAX_POINTS + 1);

  localparam int CRD_W = 24;
  localparam int SUM_W = 31;
  localparam int ABS_W = 37;
  localparam int SCL_W = 32;
  localparam int OFF_W = 48;
  localparam int DVD_W = 64;
  localparam int DSR_W = 38;

  localparam logic [SCL_W-1:0] SCALE_MAX = '1;

  typedef enum logic [1:0] {
    OP_POINT      = 2'd0,
    OP_POINT_LAST = 2'd1,
    OP_LAST_ONLY  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [PT_AW-1:0]        addr;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
  } job_t;

endpackage

@@ rtl/psn_front.sv @@
// psn_front: input side, counts the set and classifies each point
// depends on psn_pkg
module psn_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [23:0]           x_coord,
  input  logic signed [23:0]           y_coord,
  input  logic                         last_point,
  input  logic                         in_valid,
  output logic                         in_ready,
  output psn_pkg::job_t                push_data,
  output logic                         push_valid,
  input  logic                         push_ready
);
  import psn_pkg::*;

  logic [PT_CW-1:0] count;
  logic             full;
  logic             accept;

  assign full       = (count == PT_CW'(MAX_POINTS));
  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  // a point beyond the store is dropped unless it closes the set
  assign push_valid = in_valid && (!full || last_point);

  always_comb begin
    push_data.addr = count[PT_AW-1:0];
    push_data.x    = x_coord;
    push_data.y    = y_coord;
    if (full) begin
      push_data.op = OP_LAST_ONLY;
    end else if (last_point) begin
      push_data.op = OP_POINT_LAST;
    end else begin
      push_data.op = OP_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (last_point) begin
        count <= '0;
      end else if (!full) begin
        count <= count + PT_CW'(1);
      end
    end
  end

endmodule

@@ rtl/psn_queue.sv @@
// psn_queue: two-entry queue of classified points between front and back
// depends on psn_pkg
module psn_queue (
  input  logic          clk,
  input  logic          rst,
  input  psn_pkg::job_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output psn_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import psn_pkg::*;

  job_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_data   = ent[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

@@ rtl/psn_div.sv @@
// psn_div: restoring unsigned divider, one quotient bit per cycle
// depends on psn_pkg
module psn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [psn_pkg::DVD_W-1:0]   dividend,
  input  logic [psn_pkg::DSR_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [psn_pkg::DVD_W-1:0]   quot,
  output logic [psn_pkg::DSR_W-1:0]   rem
);
  import psn_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] prem;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W:0]   shifted;
  logic             step_bit;
  logic [DSR_W-1:0] step_rem;

  assign shifted  = {prem, dvd[DVD_W-1]};
  assign step_bit = (shifted >= {1'b0, dsr});
  assign step_rem = step_bit ? DSR_W'(shifted - {1'b0, dsr}) : shifted[DSR_W-1:0];
  assign quot     = dvd;
  assign rem      = prem;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      prem <= '0;
      cnt  <= '0;
    end else if (busy) begin
      prem <= step_rem;
      dvd  <= {dvd[DVD_W-2:0], step_bit};
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/psn_back.sv @@
// psn_back: point store, deviation pass, scale and offset, emission pass
// depends on psn_pkg and psn_div
module psn_back (
  input  logic                              clk,
  input  logic                              rst,
  input  psn_pkg::job_t                     q_data,
  input  logic                              q_valid,
  output logic                              q_ready,
  output logic signed [23:0]                norm_x,
  output logic signed [23:0]                norm_y,
  output logic [31:0]                       scale_x,
  output logic [31:0]                       scale_y,
  output logic signed [47:0]                offset_x,
  output logic signed [47:0]                offset_y,
  output logic                              degenerate,
  output logic                              last_out,
  output logic                              out_valid,
  input  logic                              out_ready
);
  import psn_pkg::*;

  typedef enum logic [11:0] {
    S_LOAD     = 12'b000000000001,
    S_ACC_RD   = 12'b000000000010,
    S_ACC_ADD  = 12'b000000000100,
    S_DIV_SX   = 12'b000000001000,
    S_DIV_SY   = 12'b000000010000,
    S_MUL_PX   = 12'b000000100000,
    S_DIV_PX   = 12'b000001000000,
    S_MUL_PY   = 12'b000010000000,
    S_DIV_PY   = 12'b000100000000,
    S_EMIT_RD  = 12'b001000000000,
    S_EMIT_MUL = 12'b010000000000,
    S_EMIT_FIN = 12'b100000000000
  } state_t;

  state_t                  state;
  logic [PT_CW-1:0]        n;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [ABS_W-1:0]        abs_x;
  logic [ABS_W-1:0]        abs_y;
  logic [PT_AW-1:0]        idx;
  logic [47:0]             mem [MAX_POINTS];
  logic [47:0]             rd_data;
  logic [SCL_W-1:0]        scl_x;
  logic [SCL_W-1:0]        scl_y;
  logic                    degen;
  logic signed [63:0]      prod;
  logic signed [55:0]      qf_x;
  logic signed [55:0]      qf_y;
  logic [14:0]             rf_x;
  logic [14:0]             rf_y;
  logic signed [47:0]      off_x;
  logic signed [47:0]      off_y;
  logic signed [56:0]      mx;
  logic signed [56:0]      my;
  logic                    div_run;

  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [DVD_W-1:0]        div_dvd;
  logic [DSR_W-1:0]        div_dsr;
  logic [DVD_W-1:0]        div_quot;
  logic [DSR_W-1:0]        div_rem;

  logic                    pop;
  logic                    last_idx;
  logic signed [7:0]       n_s;
  logic signed [23:0]      px;
  logic signed [23:0]      py;
  logic signed [31:0]      dev_x;
  logic signed [31:0]      dev_y;
  logic [30:0]             mag_x;
  logic [30:0]             mag_y;
  logic [13:0]             nsq;
  logic [14:0]             den;
  logic [14:0]             n128;
  logic [ABS_W-1:0]        abs_cur;
  logic [63:0]             prod_mag;
  logic                    p_neg;
  logic [14:0]             r0;
  logic signed [55:0]      q0s;
  logic signed [55:0]      qf_new;
  logic [14:0]             rf_new;
  logic [63:0]             off_mag;
  logic signed [47:0]      off_new;
  logic [SCL_W-1:0]        scl_new;
  logic signed [63:0]      t_x;
  logic signed [63:0]      t_y;
  logic signed [17:0]      e_x;
  logic signed [17:0]      e_y;
  logic                    out_load;

  function automatic logic signed [23:0] norm_round(
    input logic signed [55:0] a,
    input logic signed [17:0] e,
    input logic [PT_CW-1:0]   nn
  );
    logic signed [17:0] h;
    logic signed [17:0] w;
    logic signed [17:0] t;
    logic               neg;
    logic signed [1:0]  k;
    logic signed [57:0] v;
    h   = $signed(18'({nn, 7'b0}));
    w   = $signed(18'({nn, 8'b0}));
    // sign of the full numerator n*256*a + e
    neg = (a < 0) || (a == 0 && e < 0);
    t   = neg ? h - e : e + h;
    k   = (t < 0) ? -2'sd1 : ((t < w) ? 2'sd0 : 2'sd1);
    v   = neg ? 58'(a) - 58'(k) : 58'(a) + 58'(k);
    if (v > 58'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -58'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  psn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign q_ready  = (state == S_LOAD);
  assign pop      = q_valid && q_ready;
  assign last_idx = (idx == PT_AW'(n - PT_CW'(1)));

  assign n_s   = $signed({1'b0, n});
  assign px    = $signed(rd_data[47:24]);
  assign py    = $signed(rd_data[23:0]);
  assign dev_x = n_s * px - sum_x;
  assign dev_y = n_s * py - sum_y;
  assign mag_x = 31'(dev_x[31] ? -dev_x : dev_x);
  assign mag_y = 31'(dev_y[31] ? -dev_y : dev_y);

  assign nsq     = n * n;
  assign den     = {n, 8'b0};
  assign n128    = {1'b0, n, 7'b0};
  assign abs_cur = (state == S_DIV_SX) ? abs_x : abs_y;

  // divider operands: scale takes round(n^2 * 2^24 / A), offset takes |P| / (256 n)
  assign prod_mag = prod[63] ? 64'(-prod) : 64'(prod);
  always_comb begin
    if (state == S_DIV_SX || state == S_DIV_SY) begin
      div_dvd = DVD_W'({nsq, 24'b0}) + DVD_W'(abs_cur >> 1);
      div_dsr = DSR_W'(abs_cur);
    end else begin
      div_dvd = prod_mag;
      div_dsr = DSR_W'(den);
    end
  end

  always_comb begin
    div_start = 1'b0;
    if (!div_run) begin
      if (state == S_DIV_SX || state == S_DIV_SY) begin
        div_start = (abs_cur != '0);
      end else if (state == S_DIV_PX || state == S_DIV_PY) begin
        div_start = 1'b1;
      end
    end
  end

  assign scl_new = (div_quot[63:32] != '0) ? SCALE_MAX : div_quot[31:0];

  // floor quotient and nonnegative remainder of P / (256 n), plus rounded offset
  assign p_neg  = prod[63];
  assign r0     = div_rem[14:0];
  assign q0s    = $signed({1'b0, div_quot[54:0]});
  assign qf_new = !p_neg ? q0s : ((r0 == '0) ? -q0s : -q0s - 56'sd1);
  assign rf_new = (!p_neg || r0 == '0) ? r0 : den - r0;
  assign off_mag = div_quot + 64'(r0 >= n128);
  always_comb begin
    if (p_neg) begin
      off_new = (off_mag > 64'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : $signed(off_mag[47:0]);
    end else begin
      off_new = (off_mag > 64'h8000_0000_0000) ? 48'sh8000_0000_0000
                                                : $signed(-off_mag[47:0]);
    end
  end

  // per point: x*scale - 256*Q split into whole part and a residue against R
  assign t_x = 64'(mx) - $signed({qf_x, 8'b0});
  assign t_y = 64'(my) - $signed({qf_y, 8'b0});
  assign e_x = $signed(18'(n) * 18'(t_x[7:0])) - $signed(18'(rf_x));
  assign e_y = $signed(18'(n) * 18'(t_y[7:0])) - $signed(18'(rf_y));

  assign out_load = (state == S_EMIT_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop && q_data.op != OP_LAST_ONLY) begin
      mem[q_data.addr] <= {q_data.x, q_data.y};
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL_PX) begin
      prod <= sum_x * $signed({1'b0, scl_x});
    end else if (state == S_MUL_PY) begin
      prod <= sum_y * $signed({1'b0, scl_y});
    end
    if (state == S_EMIT_MUL) begin
      mx <= px * $signed({1'b0, scl_x});
      my <= py * $signed({1'b0, scl_y});
    end
    if (out_load) begin
      norm_x     <= norm_round(t_x[63:8], e_x, n);
      norm_y     <= norm_round(t_y[63:8], e_y, n);
      scale_x    <= scl_x;
      scale_y    <= scl_y;
      offset_x   <= off_x;
      offset_y   <= off_y;
      degenerate <= degen;
      last_out   <= last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      n         <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      idx       <= '0;
      div_run   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (div_start) begin
        div_run <= 1'b1;
      end else if (div_done) begin
        div_run <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (pop) begin
            if (q_data.op != OP_LAST_ONLY) begin
              n     <= n + PT_CW'(1);
              sum_x <= sum_x + SUM_W'(q_data.x);
              sum_y <= sum_y + SUM_W'(q_data.y);
            end
            if (q_data.op != OP_POINT) begin
              idx   <= '0;
              abs_x <= '0;
              abs_y <= '0;
              degen <= 1'b0;
              state <= S_ACC_RD;
            end
          end
        end
        S_ACC_RD: begin
          state <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          abs_x <= abs_x + ABS_W'(mag_x);
          abs_y <= abs_y + ABS_W'(mag_y);
          if (last_idx) begin
            state <= S_DIV_SX;
          end else begin
            idx   <= idx + PT_AW'(1);
            state <= S_ACC_RD;
          end
        end
        S_DIV_SX: begin
          if (abs_x == '0) begin
            scl_x <= SCALE_MAX;
            degen <= 1'b1;
            state <= S_DIV_SY;
          end else if (div_done) begin
            scl_x <= scl_new;
            state <= S_DIV_SY;
          end
        end
        S_DIV_SY: begin
          if (abs_y == '0) begin
            scl_y <= SCALE_MAX;
            degen <= 1'b1;
            state <= S_MUL_PX;
          end else if (div_done) begin
            scl_y <= scl_new;
            state <= S_MUL_PX;
          end
        end
        S_MUL_PX: begin
          state <= S_DIV_PX;
        end
        S_DIV_PX: begin
          if (div_done) begin
            qf_x  <= qf_new;
            rf_x  <= rf_new;
            off_x <= off_new;
            state <= S_MUL_PY;
          end
        end
        S_MUL_PY: begin
          state <= S_DIV_PY;
        end
        S_DIV_PY: begin
          if (div_done) begin
            qf_y  <= qf_new;
            rf_y  <= rf_new;
            off_y <= off_new;
            idx   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_MUL;
        end
        S_EMIT_MUL: begin
          state <= S_EMIT_FIN;
        end
        S_EMIT_FIN: begin
          if (out_load) begin
            if (last_idx) begin
              n     <= '0;
              sum_x <= '0;
              sum_y <= '0;
              state <= S_LOAD;
            end else begin
              idx   <= idx + PT_AW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    n <= PT_CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_full_agree: assert property (@(posedge clk) disable iff (rst)
    (pop && q_data.op == OP_LAST_ONLY) |-> (n == PT_CW'(MAX_POINTS)))
    else $error("front dropped a point while the store had room");

  a_degen_scale: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (scale_x == SCALE_MAX || scale_y == SCALE_MAX))
    else $error("degenerate set without a saturated scale");

endmodule

@@ rtl/point_set_normalizer.sv @@
// point_set_normalizer: top level, front classifier, queue and compute back end
// depends on psn_pkg, psn_front, psn_queue, psn_back, psn_div
//
// Input channel (in_valid/in_ready) takes one keypoint per transfer, signed
// Q16.8; last_point closes the set. Up to 64 points are stored; later points
// of the same set are dropped, but a dropped point marked last still closes it.
// Output channel (out_valid/out_ready) gives one normalized point per stored
// point, in arrival order, with the scale and offset terms; last_out marks the
// final one.
// Loading takes one point per cycle while the queue has room. After the
// closing point the back end makes one pass over the store (read and add
// states per point), up to four divisions on a shared 64-step bit-serial
// divider, plus two multiply states, then emits each point through the read,
// multiply and rounding steps.
// A two-entry queue lets the next set start loading while the back end is busy;
// input stalls once the queue is full. A stalled receiver holds the output
// register and halts emission. Reset clears count, sums and handshakes; the
// point store needs no clearing.
module point_set_normalizer (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [23:0] x_coord,
  input  logic signed [23:0] y_coord,
  input  logic               last_point,
  input  logic               in_valid,
  output logic               in_ready,
  output logic signed [23:0] norm_x,
  output logic signed [23:0] norm_y,
  output logic [31:0]        scale_x,
  output logic [31:0]        scale_y,
  output logic signed [47:0] offset_x,
  output logic signed [47:0] offset_y,
  output logic               degenerate,
  output logic               last_out,
  output logic               out_valid,
  input  logic               out_ready
);
  import psn_pkg::*;

  job_t push_data;
  logic push_valid;
  logic push_ready;
  job_t pop_data;
  logic pop_valid;
  logic pop_ready;

  psn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_point (last_point),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  psn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  psn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (pop_data),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .scale_x    (scale_x),
    .scale_y    (scale_y),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .degenerate (degenerate),
    .last_out   (last_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
